>>> rtl/hufd_pkg.sv
package hufd_pkg;

  // Field widths of the item and result payloads
  localparam int IDX_W  = 9;
  localparam int SYM_W  = 8;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 4;

  // Most bits one coded byte can carry
  localparam logic [CNT_W-1:0] BITS_PER_BYTE = CNT_W'(BYTE_W);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [SYM_W-1:0] sym_t;

  // Item command codes
  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_code_t;

  // One entry of the node store
  typedef struct packed {
    logic leaf;
    idx_t left;
    idx_t right;
    sym_t sym;
  } node_t;

  // Input item payload
  typedef struct packed {
    logic              command;
    idx_t              node_address;
    logic              node_is_leaf;
    idx_t              left_child;
    idx_t              right_child;
    sym_t              node_symbol;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  bit_count;
    logic              string_start;
  } item_t;

  // Controller to datapath
  typedef struct packed {
    logic wr;     // store one node
    logic load;   // latch a coded byte, fetch the start node
    logic step;   // check one reached node and walk one bit
    logic flush;  // send the held symbol as the last of the byte
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_decode;  // item on the input is a decode item
    logic bits_done;  // no bits of the byte left to walk
    logic out_free;   // output register can take a symbol this cycle
    logic pend;       // a decoded symbol is held back
  } dp_stat_t;

endpackage

>>> rtl/hufd_if.sv
// Input item channel
interface hufd_in_if;
  import hufd_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  idx_t              node_address;
  logic              node_is_leaf;
  idx_t              left_child;
  idx_t              right_child;
  sym_t              node_symbol;
  logic [BYTE_W-1:0] data_byte;
  logic [CNT_W-1:0]  bit_count;
  logic              string_start;

  modport source (
    output valid, command, node_address, node_is_leaf, left_child, right_child,
           node_symbol, data_byte, bit_count, string_start,
    input  ready
  );

  modport sink (
    input  valid, command, node_address, node_is_leaf, left_child, right_child,
           node_symbol, data_byte, bit_count, string_start,
    output ready
  );
endinterface

// Decoded symbol channel
interface hufd_out_if;
  import hufd_pkg::*;

  logic valid;
  logic ready;
  sym_t symbol;
  logic last_of_run;

  modport source (output valid, symbol, last_of_run, input ready);
  modport sink (input valid, symbol, last_of_run, output ready);
endinterface

>>> rtl/hufd_datapath.sv
module hufd_datapath #(
  parameter int MAX_NODES = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  hufd_pkg::item_t   item,
  input  hufd_pkg::dp_cmd_t cmd,
  output hufd_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output hufd_pkg::sym_t    symbol,
  output logic              last_of_run
);
  import hufd_pkg::*;

  localparam int AW = $clog2(MAX_NODES);

  // Node indexes past the store read as an internal node pointing at the root
  function automatic logic in_store(idx_t i);
    return {{(32-IDX_W){1'b0}}, i} < 32'(MAX_NODES);
  endfunction

  // Node store and its registered read port
  node_t mem [0:MAX_NODES-1];
  node_t rd_q;
  logic  rd_ok;

  // Copy of the root so a walk restarts without a fetch
  node_t root;

  // Walk state
  idx_t              pos;     // current node; walk position between bytes
  logic [BYTE_W-1:0] bits;    // remaining coded bits, next one at the top
  logic [CNT_W-1:0]  cnt;     // bits left to walk
  logic              check;   // node in view was reached by a move

  // Symbol held until we know whether it ends the byte
  sym_t pend_sym;
  logic pend;

  node_t view;
  node_t cur;
  node_t wnode;
  logic  hit;
  logic  more;
  logic  out_free;
  logic  rd_en;
  idx_t  cur_idx;
  idx_t  child;
  idx_t  load_idx;
  idx_t  rd_idx;

  // One bit of walk: leaf check on the node just reached, then pick a child
  always_comb begin
    view     = rd_ok ? rd_q : '0;
    hit      = check & view.leaf;
    cur      = hit ? root : view;
    cur_idx  = hit ? '0 : pos;
    child    = bits[BYTE_W-1] ? cur.right : cur.left;
    more     = (cnt != '0);
    load_idx = item.string_start ? '0 : pos;
    rd_idx   = cmd.load ? load_idx : child;
    rd_en    = cmd.load | (cmd.step & more);
    out_free = ~out_valid | out_ready;
    wnode    = '{leaf: item.node_is_leaf, left: item.left_child,
                 right: item.right_child, sym: item.node_symbol};
  end

  assign stat = '{is_decode: (item.command == CMD_DECODE), bits_done: ~more,
                  out_free: out_free, pend: pend};

  // Node store: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr && in_store(item.node_address)) begin
      mem[AW'(item.node_address)] <= wnode;
    end
    if (rd_en) begin
      rd_q <= mem[AW'(rd_idx)];
    end
    if (cmd.wr && item.node_address == '0) begin
      root <= wnode;
    end
  end

  // Walk, symbol hold and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok     <= 1'b0;
      pos       <= '0;
      cnt       <= '0;
      check     <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (rd_en) begin
        rd_ok <= in_store(rd_idx);
      end
      if (cmd.load) begin
        bits  <= item.data_byte;
        cnt   <= (item.bit_count > BITS_PER_BYTE) ? BITS_PER_BYTE : item.bit_count;
        check <= 1'b0;
        pos   <= load_idx;
      end
      if (cmd.step) begin
        if (hit) begin
          if (pend) begin
            out_valid   <= 1'b1;
            symbol      <= pend_sym;
            last_of_run <= 1'b0;
          end
          pend_sym <= view.sym;
          pend     <= 1'b1;
        end
        if (more) begin
          pos   <= child;
          bits  <= bits << 1;
          cnt   <= cnt - 1'b1;
          check <= 1'b1;
        end else begin
          pos   <= cur_idx;
          check <= 1'b0;
        end
      end
      if (cmd.flush && pend) begin
        out_valid   <= 1'b1;
        symbol      <= pend_sym;
        last_of_run <= 1'b1;
        pend        <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/hufd_ctrl.sv
module hufd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hufd_pkg::dp_stat_t stat,
  output hufd_pkg::dp_cmd_t  cmd
);
  import hufd_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    WALK,
    FLUSH
  } state_t;

  state_t state;
  logic   accept;

  // Commands follow the state and the input transfer
  always_comb begin
    in_ready  = (state == IDLE);
    accept    = in_valid & in_ready;
    cmd.wr    = accept & ~stat.is_decode;
    cmd.load  = accept & stat.is_decode;
    cmd.step  = (state == WALK) & stat.out_free;
    cmd.flush = (state == FLUSH) & stat.out_free;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.load) state <= WALK;
        end
        WALK: begin
          if (cmd.step && stat.bits_done) state <= FLUSH;
        end
        FLUSH: begin
          if (!stat.pend || stat.out_free) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A held symbol never survives into the next item
  a_no_pend_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !stat.pend)
    else $error("held symbol left over at item acceptance");

  a_load_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == WALK)
    else $error("decode item did not start a walk");

  a_end_flush: assert property (@(posedge clk) disable iff (rst)
    cmd.step && stat.bits_done |=> state == FLUSH)
    else $error("walk end did not reach flush");

  a_flush_wait: assert property (@(posedge clk) disable iff (rst)
    state == FLUSH && stat.pend && !stat.out_free |=> state == FLUSH)
    else $error("flush left with a symbol still held");

endmodule

>>> rtl/huffman_tree_bit_decoder.sv
// Huffman tree-walk decoder with a loadable node store.
// Input channel "item": a write item (command 0) stores one tree node at
// node_address; node 0 is the root. A decode item (command 1) walks the
// first bit_count bits of data_byte, most significant first; 0 goes left,
// 1 goes right. Each leaf reached sends its symbol on channel "result" and
// the walk returns to the root; last_of_run marks the final symbol of a byte.
// The walk position carries across bytes; string_start sends it to the root.
// A write item stores its node when it is accepted. A decode item fetches
// the start node, then walks one bit per node store read (a count above 8
// walks 8 bits), checks the final node and releases the held last symbol.
// One item is worked on at a time.
// The last symbol found is held back until the next leaf or the end of the
// byte, so an earlier symbol leaves when the next leaf of its byte is reached.
// Reset sets the walk position to the root and empties the output; the
// node store keeps no reset value and must be loaded before decoding.
// A stalled receiver holds the result register and stops the walk; a new
// item is taken while the last result of the previous one still waits.
module huffman_tree_bit_decoder #(
  parameter int MAX_NODES = 512
) (
  input logic        clk,
  input logic        rst,
  hufd_in_if.sink    item,
  hufd_out_if.source result
);
  import hufd_pkg::*;

  item_t    item_data;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Gather the item payload
  assign item_data = '{command: item.command, node_address: item.node_address,
                       node_is_leaf: item.node_is_leaf, left_child: item.left_child,
                       right_child: item.right_child, node_symbol: item.node_symbol,
                       data_byte: item.data_byte, bit_count: item.bit_count,
                       string_start: item.string_start};

  hufd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hufd_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .item        (item_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .symbol      (result.symbol),
    .last_of_run (result.last_of_run)
  );

endmodule

>>> tb/sv/huffman_tree_bit_decoder_tb.sv
module huffman_tree_bit_decoder_tb;
  import hufd_pkg::*;

  localparam int STORE_DEPTH = 512;
  localparam int ITEM_TARGET = 470;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    sym_t symbol;
    logic last_of_run;
  } decoded_sym_t;

  bit clk;
  logic rst;

  hufd_in_if  item_if ();
  hufd_out_if result_if ();

  huffman_tree_bit_decoder #(
    .MAX_NODES(STORE_DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_if),
    .result(result_if)
  );

  always #5 clk = ~clk;

  // Stimulus queue and generation-time view of which nodes hold data
  item_t pending_items[$];
  idx_t  written_list[$];
  bit    gen_written[STORE_DEPTH];

  // Predictor state: mirror of the node store and of the walk position
  node_t        node_mirror[STORE_DEPTH];
  idx_t         walk_mirror;
  decoded_sym_t expected_symbols[$];

  // Handshake and bookkeeping
  item_t       drive_item;
  bit          in_xfer;
  bit          out_xfer;
  int unsigned in_gap;
  int unsigned in_calm;
  int unsigned out_stall;
  int unsigned out_calm;
  int unsigned idle_cycles;
  bit          stuck;
  int unsigned mismatches;
  int unsigned writes_seen;
  int unsigned bytes_seen;
  int unsigned symbols_checked;

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Child link that keeps every reachable node written: self or a written node
  function automatic idx_t pick_link(input idx_t self_idx);
    if (written_list.size() == 0 || $urandom_range(0, 3) == 0) return self_idx;
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  task automatic push_node(input idx_t addr, input logic leaf, input idx_t left,
                           input idx_t right, input sym_t sym);
    item_t it;
    it.command      = CMD_WRITE;
    it.node_address = addr;
    it.node_is_leaf = leaf;
    it.left_child   = left;
    it.right_child  = right;
    it.node_symbol  = sym;
    // fields a write ignores still toggle
    it.data_byte    = BYTE_W'($urandom);
    it.bit_count    = CNT_W'($urandom);
    it.string_start = 1'($urandom);
    pending_items = {pending_items, it};
    if (!gen_written[addr]) begin
      gen_written[addr] = 1'b1;
      written_list = {written_list, addr};
    end
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] data, input logic [CNT_W-1:0] cnt,
                           input logic start);
    item_t it;
    it.command      = CMD_DECODE;
    it.node_address = IDX_W'($urandom);
    it.node_is_leaf = 1'($urandom);
    it.left_child   = IDX_W'($urandom);
    it.right_child  = IDX_W'($urandom);
    it.node_symbol  = SYM_W'($urandom);
    it.data_byte    = data;
    it.bit_count    = cnt;
    it.string_start = start;
    pending_items = {pending_items, it};
  endtask

  // Bottom-up tree build: leaves first, pairs merged, node 0 written last as root
  task automatic build_tree(input int n_leaves);
    idx_t pool[$];
    idx_t a;
    idx_t b;
    idx_t node;
    bit   used[STORE_DEPTH];
    int   i;
    int   k;
    used[0] = 1'b1;
    for (k = 0; k < n_leaves; k++) begin
      do a = IDX_W'($urandom_range(1, STORE_DEPTH - 1)); while (used[a]);
      used[a] = 1'b1;
      push_node(a, 1'b1, pick_link(a), pick_link(a), SYM_W'($urandom));
      pool = {pool, a};
    end
    while (pool.size() > 1) begin
      i = $urandom_range(0, pool.size() - 1);
      a = pool[i];
      pool.delete(i);
      i = $urandom_range(0, pool.size() - 1);
      b = pool[i];
      pool.delete(i);
      if (pool.size() == 0) begin
        node = '0;
      end else begin
        do node = IDX_W'($urandom_range(1, STORE_DEPTH - 1)); while (used[node]);
        used[node] = 1'b1;
      end
      push_node(node, 1'b0, a, b, SYM_W'($urandom));
      pool = {pool, node};
    end
  endtask

  // Random coded byte: mostly full bytes, some short, empty and oversized counts
  task automatic push_random_byte();
    int unsigned r;
    logic [CNT_W-1:0] cnt;
    r = $urandom_range(0, 99);
    if (r < 60) cnt = BITS_PER_BYTE;
    else if (r < 85) cnt = CNT_W'($urandom_range(1, 7));
    else if (r < 92) cnt = '0;
    else cnt = CNT_W'($urandom_range(9, 15));
    push_byte(BYTE_W'($urandom), cnt, $urandom_range(0, 9) == 0);
  endtask

  // Expected symbols of one accepted item; updates the mirrored state
  task automatic predict_symbols(input item_t it);
    node_t        cur;
    node_t        nxt;
    idx_t         pos;
    int unsigned  cnt;
    int unsigned  b;
    int unsigned  produced;
    decoded_sym_t r;
    if (it.command == CMD_WRITE) begin
      node_mirror[it.node_address].leaf  = it.node_is_leaf;
      node_mirror[it.node_address].left  = it.left_child;
      node_mirror[it.node_address].right = it.right_child;
      node_mirror[it.node_address].sym   = it.node_symbol;
      writes_seen++;
    end else begin
      bytes_seen++;
      if (it.string_start) walk_mirror = '0;
      cnt = (it.bit_count > BITS_PER_BYTE) ? BITS_PER_BYTE : it.bit_count;
      pos = walk_mirror;
      produced = 0;
      for (b = 0; b < cnt; b++) begin
        cur = node_mirror[pos];
        pos = it.data_byte[BYTE_W-1-b] ? cur.right : cur.left;
        nxt = node_mirror[pos];
        // leaf test follows the move; the walk restarts at the root
        if (nxt.leaf) begin
          r.symbol = nxt.sym;
          r.last_of_run = 1'b0;
          expected_symbols = {expected_symbols, r};
          produced++;
          pos = '0;
        end
      end
      walk_mirror = pos;
      if (produced > 0) begin
        expected_symbols[expected_symbols.size() - 1].last_of_run = 1'b1;
      end
    end
  endtask

  // Monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    in_xfer  = !rst && item_if.valid && item_if.ready;
    out_xfer = !rst && result_if.valid && result_if.ready;
    if (in_xfer) predict_symbols(drive_item);
    if (out_xfer) begin
      if (expected_symbols.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected symbol transfer: symbol %02h last %0b", $time,
                 result_if.symbol, result_if.last_of_run);
      end else begin
        decoded_sym_t exp_sym;
        exp_sym = expected_symbols.pop_front();
        symbols_checked++;
        if (result_if.symbol !== exp_sym.symbol) begin
          mismatches++;
          $display("%0t: symbol mismatch: expected %02h actual %02h", $time,
                   exp_sym.symbol, result_if.symbol);
        end
        if (result_if.last_of_run !== exp_sym.last_of_run) begin
          mismatches++;
          $display("%0t: last_of_run mismatch: expected %0b actual %0b", $time,
                   exp_sym.last_of_run, result_if.last_of_run);
        end
      end
    end
    // watchdog on cycles without any transfer
    if (rst || in_xfer || out_xfer) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) stuck = 1'b1;
  end

  // Driver: present items at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
    end else if (!item_if.valid || in_xfer) begin
      if (in_gap > 0) begin
        in_gap--;
        item_if.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        drive_item = pending_items.pop_front();
        item_if.command      <= drive_item.command;
        item_if.node_address <= drive_item.node_address;
        item_if.node_is_leaf <= drive_item.node_is_leaf;
        item_if.left_child   <= drive_item.left_child;
        item_if.right_child  <= drive_item.right_child;
        item_if.node_symbol  <= drive_item.node_symbol;
        item_if.data_byte    <= drive_item.data_byte;
        item_if.bit_count    <= drive_item.bit_count;
        item_if.string_start <= drive_item.string_start;
        item_if.valid        <= 1'b1;
        in_gap = (in_calm > 0) ? 0 : pick_gap();
      end else begin
        item_if.valid <= 1'b0;
      end
    end
    // stretches with no gaps
    if (in_calm > 0) in_calm--;
    else if ($urandom_range(0, 199) == 0) in_calm = $urandom_range(40, 150);
  end

  // Receiver: random stalls on ready
  always @(negedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
      if (out_calm == 0 && $urandom_range(0, 3) == 0) out_stall = pick_gap();
    end
    if (out_calm > 0) out_calm--;
    else if ($urandom_range(0, 199) == 0) out_calm = $urandom_range(40, 150);
  end

  initial begin
    int unsigned n;
    int unsigned r;
    idx_t a;
    rst = 1'b1;
    item_if.valid        = 1'b0;
    item_if.command      = CMD_WRITE;
    item_if.node_address = '0;
    item_if.node_is_leaf = 1'b0;
    item_if.left_child   = '0;
    item_if.right_child  = '0;
    item_if.node_symbol  = '0;
    item_if.data_byte    = '0;
    item_if.bit_count    = '0;
    item_if.string_start = 1'b0;
    result_if.ready      = 1'b0;
    walk_mirror = '0;

    // Directed: two leaves at the address extremes under the root
    push_node(IDX_W'(STORE_DEPTH - 1), 1'b1, IDX_W'(STORE_DEPTH - 1),
              IDX_W'(STORE_DEPTH - 1), 8'hFF);
    push_node(9'd1, 1'b1, 9'd1, 9'd1, 8'h00);
    push_node(9'd0, 1'b0, 9'd1, IDX_W'(STORE_DEPTH - 1), 8'h5A);
    push_byte(8'b0101_0101, BITS_PER_BYTE, 1'b1);   // eight symbols from one byte
    push_byte(8'hFF, 4'd0, 1'b1);                   // empty byte, restart only
    push_byte(8'hFF, 4'd15, 1'b0);                  // oversized count clips to 8
    push_byte(8'h3C, 4'd9, 1'b0);
    // self loop on node 2: bytes that reach no leaf, code word across bytes
    push_node(9'd2, 1'b0, 9'd2, IDX_W'(STORE_DEPTH - 1), 8'h11);
    push_node(9'd0, 1'b0, 9'd2, 9'd1, 8'h22);
    push_byte(8'h00, BITS_PER_BYTE, 1'b0);
    push_byte(8'h80, 4'd1, 1'b0);
    push_byte(8'h00, 4'd3, 1'b0);
    push_byte(8'h80, 4'd1, 1'b1);                   // restart changes the path
    // root as leaf: a link back to node 0 emits its symbol
    push_node(9'd0, 1'b1, 9'd0, IDX_W'(STORE_DEPTH - 1), 8'hA5);
    push_byte(8'h0F, BITS_PER_BYTE, 1'b0);
    push_byte(8'hB2, 4'd5, 1'b1);

    // Random phases: build a tree, then mostly well-formed coded bytes
    while (pending_items.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_node(9'd0, 1'b1, pick_link(9'd0), pick_link(9'd0), SYM_W'($urandom));
      end else begin
        build_tree((r < 20) ? $urandom_range(13, 40) : $urandom_range(2, 12));
      end
      for (n = $urandom_range(5, 30); n > 0; n--) begin
        if ($urandom_range(0, 99) < 8) begin
          // noise: rewrite a written node, links kept inside the written set
          a = written_list[$urandom_range(0, written_list.size() - 1)];
          push_node(a, 1'($urandom), pick_link(a), pick_link(a), SYM_W'($urandom));
        end else begin
          push_random_byte();
        end
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!stuck && (pending_items.size() > 0 || item_if.valid ||
                      expected_symbols.size() > 0))
      @(posedge clk);
    for (n = 0; n < DRAIN_CYCLES && !stuck; n++) @(posedge clk);

    if (stuck) $display("%0t: watchdog expired with no transfer", $time);
    if (expected_symbols.size() > 0)
      $display("%0t: %0d expected symbols never arrived", $time, expected_symbols.size());
    $display("Covered %0d node writes and %0d coded bytes with random gaps and stalls.",
             writes_seen, bytes_seen);
    $display("Checked %0d decoded symbols, %0d mismatches.", symbols_checked, mismatches);
    if (!stuck && mismatches == 0 && expected_symbols.size() == 0) begin
      $display("huffman_tree_bit_decoder regression: pass");
    end else begin
      $display("huffman_tree_bit_decoder regression: fail");
    end
    $finish;
  end

endmodule
